FILE: rtl/core/rrp_pkg.sv
`timescale 1ns / 1ps

package rrp_pkg;

  // Widths of the argument count and argument length datapaths.
  localparam int COUNT_BITS = 20;
  localparam int LEN_BITS   = 32;

  // Widths of the two limit registers and of the config data, fixed by the register map.
  localparam int CFG_COUNT_BITS = 20;
  localparam int CFG_LEN_BITS   = 32;
  localparam int CFG_DATA_BITS  = 32;

  // The decimal accumulator covers the wider of the two fields.
  localparam int ACC_BITS = (COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS;
  // Limit comparisons run at a width that holds both accumulator and limits.
  localparam int CMP_BITS = (ACC_BITS > CFG_LEN_BITS) ? ACC_BITS : CFG_LEN_BITS;

  // Depth of the queue between the classifier and the parser.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  // Register indexes.
  localparam logic REG_MAX_ARG_COUNT  = 1'b0;
  localparam logic REG_MAX_ARG_LENGTH = 1'b1;

  // Reset values of the limit registers.
  localparam logic [CFG_COUNT_BITS-1:0] MAX_ARG_COUNT_RESET  = CFG_COUNT_BITS'(1048575);
  localparam logic [CFG_LEN_BITS-1:0]   MAX_ARG_LENGTH_RESET = CFG_LEN_BITS'(536870912);

  // Framing characters.
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  // Parser phases.
  typedef enum logic [3:0] {
    PH_STAR     = 4'd0,
    PH_COUNT    = 4'd1,
    PH_COUNT_LF = 4'd2,
    PH_DOLLAR   = 4'd3,
    PH_LEN      = 4'd4,
    PH_LEN_LF   = 4'd5,
    PH_DATA     = 4'd6,
    PH_DATA_LF  = 4'd7,
    PH_ERROR    = 4'd8
  } phase_t;

  // Event codes shown on event_kind.
  typedef enum logic [2:0] {
    EV_FRAME = 3'd0,
    EV_COUNT = 3'd1,
    EV_START = 3'd2,
    EV_BYTE  = 3'd3,
    EV_END   = 3'd4,
    EV_ERR   = 3'd5
  } event_t;

  // One classified request byte as it travels from the front to the back.
  typedef struct packed {
    logic [7:0] data;
    logic       is_star;
    logic       is_dollar;
    logic       is_cr;
    logic       is_lf;
    logic       is_digit;
    logic [3:0] digit;
  } item_t;

  // Handshake between the queue and the parser.
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

FILE: rtl/core/resp_request_parser_unit.sv
`timescale 1ns / 1ps

// Byte-serial parser for requests made of an array of bulk strings. It takes
// one request byte per clock while in_stall is low and delivers exactly one
// event per byte, also one per clock in steady state while out_stall is low. A
// byte passes a classifying register, a four-entry queue and the parser, whose
// state update sets the rate; the event then reaches the outputs through the
// output register. The queue and the output register let either side stall
// without holding up the other. The two limit registers may be written at any
// time the block is idle; there is no clearing pass after reset.
module resp_request_parser_unit import rrp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic                     cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               data_byte,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [2:0]               event_kind,
  output logic [COUNT_BITS-1:0]    arg_index,
  output logic [LEN_BITS-1:0]      arg_length,
  output logic [COUNT_BITS-1:0]    arg_count,
  output logic [7:0]               payload_byte,
  output logic [LEN_BITS-1:0]      payload_offset,
  output logic                     request_done
);

  logic        push;
  item_t       push_item;
  logic        queue_full;
  logic        pop;
  queue_head_t head;

  // Classifying front end.
  rrp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  // Queue between front and back.
  rrp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .head      (head)
  );

  // Parser and event output.
  rrp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .event_kind     (event_kind),
    .arg_index      (arg_index),
    .arg_length     (arg_length),
    .arg_count      (arg_count),
    .payload_byte   (payload_byte),
    .payload_offset (payload_offset),
    .request_done   (request_done)
  );

endmodule

FILE: rtl/core/rrp_front.sv
`timescale 1ns / 1ps

module rrp_front import rrp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       queue_full,
  output logic       push,
  output item_t      push_item
);

  logic  stage_valid;
  item_t stage_item;
  item_t class_item;
  logic  accept;

  // Classify the incoming byte against the framing characters.
  always_comb begin
    class_item.data      = data_byte;
    class_item.is_star   = (data_byte == CHAR_STAR);
    class_item.is_dollar = (data_byte == CHAR_DOLLAR);
    class_item.is_cr     = (data_byte == CHAR_CR);
    class_item.is_lf     = (data_byte == CHAR_LF);
    class_item.is_digit  = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
    class_item.digit     = 4'(data_byte - CHAR_ZERO);
  end

  // The stage is stalled only when it holds a byte that the queue cannot take.
  assign push      = stage_valid && !queue_full;
  assign in_stall  = stage_valid && queue_full;
  assign accept    = in_valid && !in_stall;
  assign push_item = stage_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (push) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_item <= class_item;
    end
  end

endmodule

FILE: rtl/core/rrp_queue.sv
`timescale 1ns / 1ps

module rrp_queue import rrp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  item_t       push_item,
  output logic        full,
  input  logic        pop,
  output queue_head_t head
);

  item_t                     entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_CNT_BITS-1:0] fill;

  assign full       = (fill == QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign head.valid = (fill != '0);
  assign head.item  = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: rtl/core/rrp_back.sv
`timescale 1ns / 1ps

module rrp_back import rrp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic                     cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  queue_head_t              head,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [2:0]               event_kind,
  output logic [COUNT_BITS-1:0]    arg_index,
  output logic [LEN_BITS-1:0]      arg_length,
  output logic [COUNT_BITS-1:0]    arg_count,
  output logic [7:0]               payload_byte,
  output logic [LEN_BITS-1:0]      payload_offset,
  output logic                     request_done
);

  logic [CFG_COUNT_BITS-1:0] max_arg_count;
  logic [CFG_LEN_BITS-1:0]   max_arg_length;

  phase_t                phase, phase_next;
  logic [ACC_BITS-1:0]   digit_value, digit_value_next;
  logic                  digits_stopped, digits_stopped_next;
  logic                  digit_over, digit_over_next;
  logic [COUNT_BITS-1:0] count_held, count_held_next;
  logic [COUNT_BITS-1:0] index_held, index_held_next;
  logic [LEN_BITS-1:0]   length_held, length_held_next;
  logic [LEN_BITS-1:0]   offset_held, offset_held_next;

  item_t                 item;
  logic [ACC_BITS+3:0]   times_ten;
  logic [CMP_BITS-1:0]   value_cmp;
  logic                  count_exceeds;
  logic                  length_exceeds;
  logic [COUNT_BITS:0]   index_plus;
  logic                  more_args;

  event_t                ev;
  logic [7:0]            ev_byte;
  logic [LEN_BITS-1:0]   ev_offset;
  logic                  ev_done;

  assign item = head.item;

  // A byte leaves the queue whenever the output register is free or drains.
  assign pop = head.valid && (!out_valid || !out_stall);

  // Limit registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_arg_count  <= MAX_ARG_COUNT_RESET;
      max_arg_length <= MAX_ARG_LENGTH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MAX_ARG_COUNT:  max_arg_count  <= cfg_data[CFG_COUNT_BITS-1:0];
        REG_MAX_ARG_LENGTH: max_arg_length <= cfg_data[CFG_LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Decimal step: value times ten plus the new digit, with the overflow held apart.
  assign times_ten = ({4'b0, digit_value} << 3) + ({4'b0, digit_value} << 1)
                   + (ACC_BITS + 4)'(item.digit);
  assign value_cmp = CMP_BITS'(digit_value);

  // A field is above its limit if it overflowed, left its range or passed the register.
  assign count_exceeds  = digit_over
                       || (value_cmp > CMP_BITS'({COUNT_BITS{1'b1}}))
                       || (value_cmp > CMP_BITS'(max_arg_count));
  assign length_exceeds = digit_over
                       || (value_cmp > CMP_BITS'({LEN_BITS{1'b1}}))
                       || (value_cmp > CMP_BITS'(max_arg_length));

  assign index_plus = {1'b0, index_held} + 1'b1;
  assign more_args  = (index_plus < {1'b0, count_held});

  // Next phase and next held values.
  always_comb begin
    phase_next          = phase;
    digit_value_next    = digit_value;
    digits_stopped_next = digits_stopped;
    digit_over_next     = digit_over;
    count_held_next     = count_held;
    index_held_next     = index_held;
    length_held_next    = length_held;
    offset_held_next    = offset_held;
    unique case (phase)
      PH_STAR, PH_DOLLAR: begin
        if ((phase == PH_STAR) ? item.is_star : item.is_dollar) begin
          digit_value_next    = '0;
          digits_stopped_next = 1'b0;
          digit_over_next     = 1'b0;
          phase_next          = (phase == PH_STAR) ? PH_COUNT : PH_LEN;
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_COUNT, PH_LEN: begin
        if (item.is_cr) begin
          if (phase == PH_COUNT) begin
            phase_next = count_exceeds ? PH_ERROR : PH_COUNT_LF;
          end else if (length_exceeds) begin
            phase_next = PH_ERROR;
          end else begin
            length_held_next = digit_value[LEN_BITS-1:0];
            phase_next       = PH_LEN_LF;
          end
        end else if (!digits_stopped) begin
          if (!item.is_digit) begin
            digits_stopped_next = 1'b1;
          end else if (digit_over || (times_ten[ACC_BITS+3:ACC_BITS] != 4'd0)) begin
            digit_over_next = 1'b1;
          end else begin
            digit_value_next = times_ten[ACC_BITS-1:0];
          end
        end
      end
      PH_COUNT_LF: begin
        if (item.is_lf) begin
          count_held_next = digit_value[COUNT_BITS-1:0];
          index_held_next = '0;
          phase_next      = (digit_value == '0) ? PH_STAR : PH_DOLLAR;
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_LEN_LF: begin
        if (item.is_lf) begin
          offset_held_next = '0;
          phase_next       = PH_DATA;
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_DATA: begin
        if (offset_held == length_held) begin
          phase_next = item.is_cr ? PH_DATA_LF : PH_ERROR;
        end else begin
          offset_held_next = offset_held + 1'b1;
        end
      end
      PH_DATA_LF: begin
        if (item.is_lf) begin
          if (more_args) begin
            index_held_next = index_plus[COUNT_BITS-1:0];
            phase_next      = PH_DOLLAR;
          end else begin
            index_held_next = '0;
            phase_next      = PH_STAR;
          end
        end else begin
          phase_next = PH_ERROR;
        end
      end
      default: begin
        phase_next = PH_ERROR;
      end
    endcase
  end

  // Event produced by the current byte.
  always_comb begin
    ev        = EV_FRAME;
    ev_byte   = 8'd0;
    ev_offset = '0;
    ev_done   = 1'b0;
    unique case (phase)
      PH_COUNT_LF: begin
        ev      = EV_COUNT;
        ev_done = (digit_value == '0);
      end
      PH_LEN_LF: begin
        ev = EV_START;
      end
      PH_DATA: begin
        if (offset_held != length_held) begin
          ev        = EV_BYTE;
          ev_byte   = item.data;
          ev_offset = offset_held;
        end
      end
      PH_DATA_LF: begin
        ev      = EV_END;
        ev_done = !more_args;
      end
      default: ;
    endcase
    // Any byte that leaves or keeps the parser in error reports only the error.
    if (phase_next == PH_ERROR) begin
      ev        = EV_ERR;
      ev_byte   = 8'd0;
      ev_offset = '0;
      ev_done   = 1'b0;
    end
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_STAR;
      digit_value    <= '0;
      digits_stopped <= 1'b0;
      digit_over     <= 1'b0;
      count_held     <= '0;
      index_held     <= '0;
      length_held    <= '0;
      offset_held    <= '0;
    end else if (pop) begin
      phase          <= phase_next;
      digit_value    <= digit_value_next;
      digits_stopped <= digits_stopped_next;
      digit_over     <= digit_over_next;
      count_held     <= count_held_next;
      index_held     <= index_held_next;
      length_held    <= length_held_next;
      offset_held    <= offset_held_next;
    end
  end

  // Output register: filled on each pop, emptied when the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      event_kind     <= ev;
      arg_index      <= index_held_next;
      arg_length     <= length_held_next;
      arg_count      <= count_held_next;
      payload_byte   <= ev_byte;
      payload_offset <= ev_offset;
      request_done   <= ev_done;
    end
  end

endmodule

FILE: rtl/core/rrp_checker.sv
`timescale 1ns / 1ps

module rrp_checker import rrp_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [2:0]            event_kind,
  input logic [COUNT_BITS-1:0] arg_index,
  input logic [LEN_BITS-1:0]   arg_length,
  input logic [7:0]            payload_byte,
  input logic [LEN_BITS-1:0]   payload_offset,
  input logic                  request_done
);

  // A stalled event stays on the port with its kind, offset and index unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_kind)
      && $stable(payload_offset) && $stable(arg_index))
    else $error("stalled event changed");

  // Only the defined event codes appear.
  a_event_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (event_kind <= EV_ERR))
    else $error("undefined event code");

  // A request completes only on a count or an argument end event.
  a_done_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && request_done |-> (event_kind == EV_COUNT) || (event_kind == EV_END))
    else $error("request done on wrong event");

  // A payload byte always lies inside its argument.
  a_offset_in_arg: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == EV_BYTE) |-> payload_offset < arg_length)
    else $error("payload offset beyond argument length");

  // Payload fields are zero on every other event.
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind != EV_BYTE) |-> (payload_byte == 8'd0) && (payload_offset == '0))
    else $error("payload fields set outside a payload event");

endmodule

bind resp_request_parser_unit rrp_checker u_checker (.*);
